// ===== hw/rtl/tmr_pkg.sv =====
// Shared types and constants for the one-shot software timer table.
// Used by the channel interfaces, the slot memory, the controller and the APB register block.
package tmr_pkg;

  localparam int SLOTS_DEF = 10;

  localparam int KIND_W = 2;
  localparam int TAG_W = 16;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-3:0] REG_SINGLE_TASK = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_TICK   = 2'd2
  } tmr_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } tmr_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  handler;
    logic [DATA_W-1:0] arg;
    logic [DATA_W-1:0] deadline;
  } tmr_entry_t;

  typedef struct packed {
    logic              create_ok;
    logic [SLOT_W-1:0] created_slot;
    logic              fired;
    logic [TAG_W-1:0]  fired_handler;
    logic [DATA_W-1:0] fired_arg;
    logic              switch_request;
  } tmr_rsp_t;

  typedef struct packed {
    logic one_task;
  } tmr_cfg_t;

endpackage

// ===== hw/rtl/tmr_if.sv =====
// Request and response channel interfaces of the timer table.
// Depends on tmr_pkg for the field widths.
interface tmr_req_if;
  logic                          valid;
  logic                          ready;
  logic [tmr_pkg::KIND_W-1:0]    kind;
  logic [tmr_pkg::TAG_W-1:0]     handler_tag;
  logic [tmr_pkg::DATA_W-1:0]    arg_token;
  logic [tmr_pkg::DATA_W-1:0]    timeout;
  logic [tmr_pkg::SLOT_W-1:0]    slot_index;

  modport source(output valid, kind, handler_tag, arg_token, timeout, slot_index,
                 input ready);
  modport sink(input valid, kind, handler_tag, arg_token, timeout, slot_index,
               output ready);
endinterface

interface tmr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          create_ok;
  logic [tmr_pkg::SLOT_W-1:0]    created_slot;
  logic                          fired;
  logic [tmr_pkg::TAG_W-1:0]     fired_handler;
  logic [tmr_pkg::DATA_W-1:0]    fired_arg;
  logic                          switch_request;

  modport source(output valid, create_ok, created_slot, fired, fired_handler, fired_arg,
                 switch_request, input ready);
  modport sink(input valid, create_ok, created_slot, fired, fired_handler, fired_arg,
               switch_request, output ready);
endinterface

// ===== hw/rtl/one_shot_software_timer_table.sv =====
// Top level of the one-shot software timer table. Depends on tmr_pkg, tmr_if, tmr_mem,
// tmr_apb and tmr_ctrl.
// The block takes one request at a time and returns exactly one response per request.
// Create, delete and unknown requests go straight from idle to the done state, where the
// response moves into the output register as soon as that register is free.
// A tick walks the slot memory one entry per cycle through its single read port and
// stops at the first expired live slot or after the last slot, then enters the done state.
// A finished response waits in the output register while the next request is already taken.
// The single-task mode bit is register 0 of the APB port.
module one_shot_software_timer_table #(
  parameter int SLOTS = tmr_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  tmr_req_if.sink                           req,
  tmr_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tmr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tmr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tmr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  tmr_pkg::tmr_cfg_t    cfg;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  tmr_pkg::tmr_entry_t  mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  tmr_pkg::tmr_entry_t  mem_rdata;

  tmr_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmr_mem #(
    .DEPTH (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tmr_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== hw/rtl/tmr_mem.sv =====
// Slot memory: handler tag, argument token and deadline of every timer slot.
// One write port, one read port with registered read data. Depends on tmr_pkg.
module tmr_mem #(
  parameter int DEPTH = tmr_pkg::SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  tmr_pkg::tmr_entry_t wdata,
  input  logic [IDX_W-1:0]    raddr,
  output tmr_pkg::tmr_entry_t rdata
);

  tmr_pkg::tmr_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tmr_apb.sv =====
// APB register block holding the single-task mode bit.
// Depends on tmr_pkg for the address map and the configuration struct.
module tmr_apb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tmr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tmr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tmr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output tmr_pkg::tmr_cfg_t                 cfg
);

  logic                                one_task;
  logic [tmr_pkg::APB_ADDR_W-3:0]      reg_idx;
  logic                                wr;

  assign reg_idx = paddr[tmr_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_task <= 1'b0;
    end else if (wr && reg_idx == tmr_pkg::REG_SINGLE_TASK) begin
      one_task <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tmr_pkg::REG_SINGLE_TASK) begin
      prdata[0] = one_task;
    end
  end

  assign cfg.one_task = one_task;

endmodule

// ===== hw/rtl/tmr_ctrl.sv =====
// Request sequencer of the timer table: live-slot bits, tick counter, expiry scan
// over the slot memory and the response register. Depends on tmr_pkg and tmr_if.
module tmr_ctrl #(
  parameter int SLOTS = tmr_pkg::SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  tmr_req_if.sink              req,
  tmr_rsp_if.source            rsp,
  input  tmr_pkg::tmr_cfg_t    cfg,
  output logic                 mem_we,
  output logic [IDX_W-1:0]     mem_waddr,
  output tmr_pkg::tmr_entry_t  mem_wdata,
  output logic [IDX_W-1:0]     mem_raddr,
  input  tmr_pkg::tmr_entry_t  mem_rdata
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  tmr_pkg::tmr_state_t           state;
  logic [SLOTS-1:0]              live;
  logic [tmr_pkg::DATA_W-1:0]    tick_count;
  logic [IDX_W-1:0]              chk_idx;
  tmr_pkg::tmr_rsp_t             pend;
  tmr_pkg::tmr_rsp_t             obuf;
  logic                          ovalid;

  logic                          accept;
  logic                          free_found;
  logic [IDX_W-1:0]              free_idx;
  logic                          create_go;
  logic                          del_go;
  logic                          hit;
  logic                          scan_last;
  logic                          load;
  tmr_pkg::tmr_rsp_t             start_rsp;
  tmr_pkg::tmr_rsp_t             fire_rsp;

  assign req.ready = (state == tmr_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign create_go = accept && req.kind == tmr_pkg::KIND_CREATE && req.handler_tag != '0 &&
                     req.timeout != '0 && free_found;
  assign del_go    = ({1'b0, req.slot_index} < (tmr_pkg::SLOT_W + 1)'(SLOTS));

  assign mem_we             = create_go;
  assign mem_waddr          = free_idx;
  assign mem_wdata.handler  = req.handler_tag;
  assign mem_wdata.arg      = req.arg_token;
  assign mem_wdata.deadline = tick_count + req.timeout;

  assign scan_last = (chk_idx == LAST_IDX);
  assign mem_raddr = (state == tmr_pkg::ST_SCAN && !scan_last) ? chk_idx + 1'b1 : '0;
  assign hit       = (state == tmr_pkg::ST_SCAN) && live[chk_idx] &&
                     (mem_rdata.deadline <= tick_count);

  assign load = (state == tmr_pkg::ST_DONE) && (!ovalid || rsp.ready);

  always_comb begin
    start_rsp                = '0;
    start_rsp.create_ok      = create_go;
    start_rsp.created_slot   = create_go ? tmr_pkg::SLOT_W'(free_idx) : '0;
    start_rsp.switch_request = (req.kind == tmr_pkg::KIND_TICK) && !cfg.one_task;
  end

  always_comb begin
    fire_rsp               = pend;
    fire_rsp.fired         = 1'b1;
    fire_rsp.fired_handler = mem_rdata.handler;
    fire_rsp.fired_arg     = mem_rdata.arg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tmr_pkg::ST_IDLE;
      live       <= '0;
      tick_count <= '0;
      ovalid     <= 1'b0;
      chk_idx    <= '0;
      pend       <= '0;
      obuf       <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        obuf   <= pend;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end

      case (state)
        tmr_pkg::ST_IDLE: begin
          if (accept) begin
            pend  <= start_rsp;
            state <= (req.kind == tmr_pkg::KIND_TICK) ? tmr_pkg::ST_SCAN : tmr_pkg::ST_DONE;
            case (req.kind)
              tmr_pkg::KIND_CREATE: begin
                if (create_go) begin
                  live[free_idx] <= 1'b1;
                end
              end
              tmr_pkg::KIND_DELETE: begin
                if (del_go) begin
                  live[req.slot_index[IDX_W-1:0]] <= 1'b0;
                end
              end
              tmr_pkg::KIND_TICK: begin
                tick_count <= tick_count + 1'b1;
                chk_idx    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        tmr_pkg::ST_SCAN: begin
          if (hit) begin
            pend          <= fire_rsp;
            live[chk_idx] <= 1'b0;
            state         <= tmr_pkg::ST_DONE;
          end else if (scan_last) begin
            state <= tmr_pkg::ST_DONE;
          end else begin
            chk_idx <= chk_idx + 1'b1;
          end
        end
        tmr_pkg::ST_DONE: begin
          if (load) begin
            state <= tmr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= tmr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = ovalid;
  assign rsp.create_ok      = obuf.create_ok;
  assign rsp.created_slot   = obuf.created_slot;
  assign rsp.fired          = obuf.fired;
  assign rsp.fired_handler  = obuf.fired_handler;
  assign rsp.fired_arg      = obuf.fired_arg;
  assign rsp.switch_request = obuf.switch_request;

endmodule
